>>> rtl/gpjt_pkg.sv
// Shared types and constants for the game port joystick timer.
`default_nettype none

package gpjt_pkg;

    localparam int AXES       = 4;
    localparam int PRESCALE_W = 4;
    localparam int TICK_DIVIDE_DEFAULT = 8;
    localparam logic [7:0] AXIS_CENTER = 8'd128;

    typedef enum logic [2:0] {
        CMD_TICK       = 3'd0,
        CMD_PORT_READ  = 3'd1,
        CMD_PORT_WRITE = 3'd2,
        CMD_SET_BUTTON = 3'd3,
        CMD_SET_AXIS   = 3'd4
    } cmd_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic       stick;
        logic       which;
        logic       pressed;
        logic [7:0] axis_value;
    } item_t;

endpackage

`default_nettype wire

>>> rtl/gpjt_core.sv
// Button, axis position and one-shot counter state with the per-command update logic.
`default_nettype none

module gpjt_core
    import gpjt_pkg::*;
#(
    parameter int TICK_DIVIDE = TICK_DIVIDE_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire item_t       item,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_mask,
    output logic [7:0]       read_data
);

    localparam logic [PRESCALE_W-1:0] PRESCALE_LOAD = PRESCALE_W'(TICK_DIVIDE);

    logic [AXES-1:0]       button_reg, button_next;
    logic [7:0]            position_reg [AXES];
    logic [7:0]            position_next [AXES];
    logic [7:0]            counter_reg [AXES];
    logic [7:0]            counter_next [AXES];
    logic [PRESCALE_W-1:0] prescale_reg, prescale_next;
    logic [1:0]            mask_reg, mask_next;

    logic [1:0]            idx;
    logic [PRESCALE_W-1:0] prescale_dec;
    logic                  count_tick;

    assign idx = {item.stick, item.which};

    // The prescaler wraps from zero to all ones, so a zero value still counts down.
    assign prescale_dec = (prescale_reg == '0) ? '1 : prescale_reg - 1'b1;

    always_comb
    begin
        button_next   = button_reg;
        position_next = position_reg;
        counter_next  = counter_reg;
        prescale_next = prescale_reg;
        mask_next     = mask_reg;
        count_tick    = 1'b0;
        read_data     = '0;

        if (step)
        begin
            unique case (cmd_t'(item.cmd))
                CMD_TICK:
                begin
                    if (prescale_dec != '0)
                    begin
                        prescale_next = prescale_dec;
                    end
                    else
                    begin
                        prescale_next = PRESCALE_LOAD;
                        count_tick    = 1'b1;
                    end
                end
                CMD_PORT_READ:
                begin
                    for (int i = 0; i < AXES; i++)
                    begin
                        read_data[4+i] = ~button_reg[i];
                        read_data[i]   = (counter_reg[i] != '0);
                    end
                end
                CMD_PORT_WRITE:
                begin
                    counter_next = position_reg;
                end
                CMD_SET_BUTTON:
                begin
                    button_next[idx] = item.pressed;
                end
                CMD_SET_AXIS:
                begin
                    position_next[idx] = item.axis_value;
                end
                default:
                begin
                end
            endcase
        end

        if (count_tick)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                if (mask_reg[i/2] && counter_reg[i] != '0)
                begin
                    counter_next[i] = counter_reg[i] - 1'b1;
                end
            end
        end

        if (cfg_we)
        begin
            mask_next = cfg_mask;
            for (int i = 0; i < AXES; i++)
            begin
                position_next[i] = AXIS_CENTER;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            button_reg   <= '0;
            prescale_reg <= PRESCALE_LOAD;
            mask_reg     <= '0;
            for (int i = 0; i < AXES; i++)
            begin
                position_reg[i] <= AXIS_CENTER;
                counter_reg[i]  <= '0;
            end
        end
        else
        begin
            button_reg    <= button_next;
            position_reg  <= position_next;
            counter_reg   <= counter_next;
            prescale_reg  <= prescale_next;
            mask_reg      <= mask_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/game_port_joystick_timer.sv
// Top level of the game port joystick timer: input register, state core and result register.
`default_nettype none

// Two-stick game port model. Every accepted command beat yields exactly one result beat on
// the master side; read_data is the port byte for a port read and zero for any other command.
// The block takes one beat per clock unless the result register is stalled: an accepted beat
// waits in the input register until it advances, is then applied to the button, axis and
// counter state, and its result is loaded into the output register that drives m_tvalid,
// so throughput is set only by the result register draining. Configuration writes to the
// connected mask are taken at any time but belong only while the block is idle; each write
// also returns all axis positions to center.
module game_port_joystick_timer
    import gpjt_pkg::*;
#(
    parameter int TICK_DIVIDE = TICK_DIVIDE_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // stick, which, pressed, axis_value[7:0], zero fill
    input  wire logic [2:0]  s_tuser,   // cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // read_data
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_data
);

    logic       in_valid_reg;
    item_t      item_reg;
    logic       out_valid_reg;
    logic [7:0] out_data_reg;
    logic       advance;
    logic [7:0] read_data;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg.cmd        <= s_tuser;
            item_reg.stick      <= s_tdata[0];
            item_reg.which      <= s_tdata[1];
            item_reg.pressed    <= s_tdata[2];
            item_reg.axis_value <= s_tdata[10:3];
        end
        if (advance)
        begin
            out_data_reg <= read_data;
        end
    end

    gpjt_core #(
        .TICK_DIVIDE (TICK_DIVIDE)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (item_reg),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_mask  (cfg_data),
        .read_data (read_data)
    );

`ifndef ASSERT_OFF
    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("processed beat did not reach the output register");

    a_non_read_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item_reg.cmd != CMD_PORT_READ) |=> (m_tdata == 8'd0))
        else $error("non-read command produced nonzero read_data");

    a_held_item_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(item_reg)))
        else $error("stalled input register lost or changed its beat");
`endif

endmodule

`default_nettype wire

>>> test/tb.sv
// Self-checking testbench for the game port joystick timer.
`timescale 1ns / 100ps

module tb;
    import gpjt_pkg::*;

    localparam logic [2:0] CMD_BAD_FIRST = 3'd5;
    localparam logic [2:0] CMD_BAD_MID   = 3'd6;
    localparam logic [2:0] CMD_BAD_LAST  = 3'd7;
    localparam logic [3:0] DIVIDE        = 4'(TICK_DIVIDE_DEFAULT);
    localparam logic [1:0] MASK_NONE     = 2'd0;
    localparam logic [1:0] MASK_STICK0   = 2'd1;
    localparam logic [1:0] MASK_STICK1   = 2'd2;
    localparam logic [1:0] MASK_BOTH     = 2'd3;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASE_ITEMS     = 260;
    localparam int DRAIN_CYCLES    = 4;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // stick, which, pressed, axis_value[7:0], zero fill
    logic [2:0]  s_tuser;   // cmd
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // read_data
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_data;

    // Predicted port state.
    logic       btn_state [4];
    logic [7:0] axis_pos  [4];
    logic [7:0] axis_cnt  [4];
    logic [3:0] prescale;
    logic [1:0] connected;

    logic [7:0] expected_port_bytes [$];
    logic [7:0] want_byte;

    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int error_count;
    int items_sent;
    int results_checked;
    int mask_writes;
    int cycle_count;

    game_port_joystick_timer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic rand_bit();
        return 1'($urandom_range(1));
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] apply_port_command(input logic [2:0] cmd, input logic stick,
                                                      input logic which, input logic pressed,
                                                      input logic [7:0] axis);
        int         k;
        int         i;
        logic [3:0] p;
        logic [7:0] port_byte;
        k = int'({stick, which});
        port_byte = '0;
        case (cmd)
            CMD_TICK:
            begin
                p = (prescale == 4'd0) ? 4'd15 : prescale - 4'd1;
                if (p != 4'd0)
                    prescale = p;
                else
                begin
                    prescale = DIVIDE;
                    for (i = 0; i < 4; i++)
                        if (connected[i / 2] && axis_cnt[i] != 8'd0)
                            axis_cnt[i] = axis_cnt[i] - 8'd1;
                end
            end
            CMD_PORT_READ:
                for (i = 0; i < 4; i++)
                begin
                    port_byte[4 + i] = !btn_state[i];
                    port_byte[i]     = (axis_cnt[i] != 8'd0);
                end
            CMD_PORT_WRITE:
                for (i = 0; i < 4; i++)
                    axis_cnt[i] = axis_pos[i];
            CMD_SET_BUTTON:
                btn_state[k] = pressed;
            CMD_SET_AXIS:
                axis_pos[k] = axis;
            default:
                ;
        endcase
        return port_byte;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        error_count++;
        if (error_count <= 40)
            $display("mismatch in %s at cycle %0d: got %02h, expected %02h",
                     what, cycle_count, got, want);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_port_bytes.size() == 0)
                report_mismatch("unexpected result beat", m_tdata, 8'h00);
            else
            begin
                want_byte = expected_port_bytes.pop_front();
                if (m_tdata !== want_byte)
                    report_mismatch("read_data", m_tdata, want_byte);
                results_checked++;
            end
        end
    end

    // The receiver stalls at random, or for a counted hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready = 1'b0;
            hold_left--;
        end
        else
            m_tready = ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_item(input logic [2:0] cmd, input logic stick, input logic which,
                             input logic pressed, input logic [7:0] axis);
        @(negedge clk);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = {5'b0, axis, pressed, which, stick};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_port_bytes.push_back(apply_port_command(cmd, stick, which, pressed, axis));
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (expected_port_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_mask(input logic [1:0] mask);
        int i;
        wait_drained();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = mask;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        connected = mask;
        for (i = 0; i < 4; i++)
            axis_pos[i] = AXIS_CENTER;
        mask_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [7:0] pick_axis();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return 8'($urandom_range(3));
        else if (r < 80)
            return 8'($urandom_range(15));
        return rand_byte();
    endfunction

    task automatic send_random_item();
        logic [2:0] cmd;
        if ($urandom_range(99) < 10)
            cmd = 3'($urandom_range(CMD_BAD_LAST, CMD_BAD_FIRST));
        else
            cmd = 3'($urandom_range(CMD_SET_AXIS, CMD_TICK));
        send_item(cmd, rand_bit(), rand_bit(), rand_bit(), rand_byte());
    endtask

    // Load a few axes, start the one-shots and watch them run down with ticks and reads.
    task automatic run_timer_sequence(output int count);
        int n;
        int sets;
        int i;
        sets = $urandom_range(1, 3);
        n = $urandom_range(8, 40);
        for (i = 0; i < sets; i++)
            send_item(CMD_SET_AXIS, rand_bit(), rand_bit(), rand_bit(), pick_axis());
        send_item(CMD_PORT_WRITE, rand_bit(), rand_bit(), rand_bit(), rand_byte());
        for (i = 0; i < n; i++)
            send_item(($urandom_range(99) < 80) ? CMD_TICK : CMD_PORT_READ,
                      rand_bit(), rand_bit(), rand_bit(), rand_byte());
        send_item(CMD_PORT_READ, 1'b0, 1'b0, 1'b0, 8'h00);
        count = sets + n + 2;
    endtask

    task automatic test_reset_values();
        int k;
        send_item(CMD_PORT_READ, 1'b0, 1'b0, 1'b0, 8'h00);
        for (k = 0; k < 4; k++)
            send_item(CMD_SET_BUTTON, k[1], k[0], 1'b1, 8'hff);
        send_item(CMD_PORT_READ, 1'b1, 1'b1, 1'b1, 8'hff);
        send_item(CMD_SET_BUTTON, 1'b0, 1'b1, 1'b0, 8'h00);
        send_item(CMD_SET_BUTTON, 1'b1, 1'b0, 1'b0, 8'h00);
        send_item(CMD_PORT_READ, 1'b0, 1'b0, 1'b0, 8'h00);
    endtask

    task automatic test_axis_timers();
        write_mask(MASK_BOTH);
        send_item(CMD_SET_AXIS, 1'b0, 1'b0, 1'b0, 8'd0);
        send_item(CMD_SET_AXIS, 1'b0, 1'b1, 1'b1, 8'd1);
        send_item(CMD_SET_AXIS, 1'b1, 1'b0, 1'b0, 8'd255);
        send_item(CMD_SET_AXIS, 1'b1, 1'b1, 1'b1, 8'd2);
        send_item(CMD_PORT_WRITE, 1'b1, 1'b1, 1'b1, 8'hff);
        send_item(CMD_PORT_READ, 1'b0, 1'b0, 1'b0, 8'h00);
        // Two full prescaler periods drain the short counters; a third proves they stop at zero.
        repeat (24) send_item(CMD_TICK, rand_bit(), rand_bit(), rand_bit(), rand_byte());
        send_item(CMD_PORT_READ, 1'b0, 1'b0, 1'b0, 8'h00);
        send_item(CMD_BAD_FIRST, 1'b1, 1'b1, 1'b1, 8'hff);
        send_item(CMD_BAD_MID, 1'b0, 1'b1, 1'b0, 8'h55);
        send_item(CMD_BAD_LAST, 1'b1, 1'b0, 1'b1, 8'haa);
        send_item(CMD_PORT_READ, 1'b0, 1'b0, 1'b0, 8'h00);
        // Only stick 0 connected: stick 1 counters hold on counting ticks.
        write_mask(MASK_STICK0);
        send_item(CMD_SET_AXIS, 1'b0, 1'b0, 1'b0, 8'd1);
        send_item(CMD_PORT_WRITE, 1'b0, 1'b0, 1'b0, 8'h00);
        repeat (8) send_item(CMD_TICK, 1'b0, 1'b0, 1'b0, 8'h00);
        send_item(CMD_PORT_READ, 1'b0, 1'b0, 1'b0, 8'h00);
        write_mask(MASK_STICK1);
        repeat (8) send_item(CMD_TICK, 1'b1, 1'b1, 1'b1, 8'hff);
        send_item(CMD_PORT_READ, 1'b0, 1'b0, 1'b0, 8'h00);
        write_mask(MASK_NONE);
        send_item(CMD_PORT_WRITE, 1'b0, 1'b0, 1'b0, 8'h00);
        repeat (8) send_item(CMD_TICK, 1'b0, 1'b0, 1'b0, 8'h00);
        send_item(CMD_PORT_READ, 1'b0, 1'b0, 1'b0, 8'h00);
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input logic [1:0] mask);
        int count;
        int n;
        write_mask(mask);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        count = 0;
        while (count < PHASE_ITEMS)
        begin
            if ($urandom_range(99) < 70)
            begin
                run_timer_sequence(n);
                count += n;
            end
            else
            begin
                send_random_item();
                count++;
            end
        end
    endtask

    task automatic test_backpressure();
        int i;
        wait_drained();
        hold_left = HOLD_OFF_CYCLES;
        for (i = 0; i < 40; i++)
            send_random_item();
        wait_drained();
        for (i = 0; i < 10; i++)
            send_random_item();
    endtask

    initial
    begin
        int k;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_TICK;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = MASK_NONE;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left = 0;
        error_count = 0;
        items_sent = 0;
        results_checked = 0;
        mask_writes = 0;
        cycle_count = 0;
        for (k = 0; k < 4; k++)
        begin
            btn_state[k] = 1'b0;
            axis_pos[k] = AXIS_CENTER;
            axis_cnt[k] = 8'd0;
        end
        prescale = DIVIDE;
        connected = MASK_NONE;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_values();
        test_axis_timers();
        test_random_traffic(35, 55, MASK_BOTH);
        test_random_traffic(55, 35, $urandom_range(1) ? MASK_STICK0 : MASK_STICK1);
        test_random_traffic(0, 0, 2'($urandom_range(3)));
        test_backpressure();

        wait_drained();
        repeat (10) @(posedge clk);
        $display("covered %0d command beats and %0d checked port bytes over %0d mask writes",
                 items_sent, results_checked, mask_writes);
        $display("idle mixes 35/55, 55/35 and none, plus a %0d-cycle output hold-off",
                 HOLD_OFF_CYCLES);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
